[rtl/core/lrt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Longest-remaining-time scheduler package
// Request codes, sequencer states and the control group of the selection unit.
// ----------------------------------------------------------------------------
package lrt_pkg;

   localparam logic [1:0] REQ_LOAD    = 2'd0;
   localparam logic [1:0] REQ_TICK    = 2'd1;
   localparam logic [1:0] REQ_RESTART = 2'd2;
   localparam logic [1:0] REQ_UNUSED  = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_FINAL,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic clear;
      logic enable;
   } sel_ctrl_type;

endpackage

[rtl/core/lrt_select.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selection unit
// One comparator that is fed one slot per cycle and keeps the best candidate.
// ----------------------------------------------------------------------------
module lrt_select import lrt_pkg::*; #(
   parameter int TIME_BITS = 16,
   parameter int IDX_W     = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  sel_ctrl_type         ctrl,
   input  logic                 entry_valid,
   input  logic [IDX_W-1:0]     entry_idx,
   input  logic [TIME_BITS-1:0] entry_rem,
   input  logic [TIME_BITS-1:0] entry_arr,
   input  logic [TIME_BITS-1:0] entry_burst,
   input  logic [TIME_BITS-1:0] cur_tick,
   output logic                 best_found,
   output logic [IDX_W-1:0]     best_idx,
   output logic [TIME_BITS-1:0] best_rem,
   output logic [TIME_BITS-1:0] best_arr,
   output logic [TIME_BITS-1:0] best_burst
);

   logic                 found_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [TIME_BITS-1:0] rem_ff;
   logic [TIME_BITS-1:0] arr_ff;
   logic [TIME_BITS-1:0] burst_ff;
   logic                 take;

   // Strictly greater keeps the lowest index on a tie, as slots arrive in order.
   assign take = ctrl.enable && entry_valid && (entry_rem != '0) &&
                 (entry_arr <= cur_tick) && (!found_ff || (entry_rem > rem_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (ctrl.clear) begin
         found_ff <= 1'b0;
      end else if (take) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         idx_ff   <= entry_idx;
         rem_ff   <= entry_rem;
         arr_ff   <= entry_arr;
         burst_ff <= entry_burst;
      end
   end

   assign best_found = found_ff;
   assign best_idx   = idx_ff;
   assign best_rem   = rem_ff;
   assign best_arr   = arr_ff;
   assign best_burst = burst_ff;

endmodule

[rtl/core/longest_remaining_time_scheduler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Longest-remaining-time-first scheduler
// Preemptive scheduler over a table of process slots held in one memory.
// ----------------------------------------------------------------------------
// A tick scans the slot table, reading one slot per cycle into one comparator, then passes
// through a write-back state and a result-forming state before it presents its result; load,
// restart and the unused code present theirs in the cycle after acceptance.
// Only one transaction is in flight: the block is ready again the cycle after the result is
// taken, and a stalled result holds off the next request.
// Reset clears the sequencer, time counter and slot valid bits; the memory is not cleared.
module longest_remaining_time_scheduler import lrt_pkg::*; #(
   parameter int NUM_SLOTS = 16,
   parameter int TIME_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // slot_index, arrival_time, burst_time, zero pad
   input  logic [1:0]  req_tuser,  // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // chosen_slot, finished, turnaround, waiting, zero pad
   output logic [0:0]  rsp_tuser   // is_idle
);

   localparam int IDX_W  = $clog2(NUM_SLOTS);
   localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
   localparam int WORD_W = 3 * TIME_BITS;
   localparam int WIDE_W = (TIME_BITS > 16) ? TIME_BITS : 16;
   localparam int TAT_W  = (TIME_BITS + 1 > 16) ? TIME_BITS + 1 : 16;
   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

   function automatic logic [TIME_BITS-1:0] clamp_time(input logic [15:0] v);
      logic [WIDE_W-1:0] w;
      w = WIDE_W'(v);
      if (w > WIDE_W'(TIME_MAX)) begin
         clamp_time = TIME_MAX;
      end else begin
         clamp_time = w[TIME_BITS-1:0];
      end
   endfunction

   // Request fields
   logic [3:0]  req_slot;
   logic [15:0] req_arrival;
   logic [15:0] req_burst;
   logic [1:0]  req_type;
   logic        req_fire;
   logic        slot_ok;

   assign req_slot    = req_tdata[3:0];
   assign req_arrival = req_tdata[19:4];
   assign req_burst   = req_tdata[35:20];
   assign req_type    = req_tuser;
   assign req_fire    = req_tvalid && req_tready;
   assign slot_ok     = 32'(req_slot) < 32'(NUM_SLOTS);

   // Sequencer and datapath registers
   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       scan_cnt_ff, scan_cnt_in;
   logic [TIME_BITS-1:0]   tick_ff, tick_in;
   logic [NUM_SLOTS-1:0]   valid_ff, valid_in;
   logic                   cmp_en_ff;
   logic [IDX_W-1:0]       cmp_idx_ff;
   logic [TAT_W-1:0]       tat_ff, tat_in;
   logic                   fin_ff, fin_in;
   logic                   rsp_idle_ff, rsp_idle_in;
   logic [3:0]             rsp_slot_ff, rsp_slot_in;
   logic                   rsp_fin_ff, rsp_fin_in;
   logic [15:0]            rsp_tat_ff, rsp_tat_in;
   logic [15:0]            rsp_wait_ff, rsp_wait_in;

   // Slot memory: burst, arrival and remaining time in one word
   logic [WORD_W-1:0]      mem [NUM_SLOTS];
   logic [WORD_W-1:0]      rd_data_ff;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;
   logic [WORD_W-1:0]      mem_wdata;

   sel_ctrl_type           sel_ctrl;
   logic                   best_found;
   logic [IDX_W-1:0]       best_idx;
   logic [TIME_BITS-1:0]   best_rem;
   logic [TIME_BITS-1:0]   best_arr;
   logic [TIME_BITS-1:0]   best_burst;

   logic [15:0]            tat_sat;
   logic [WIDE_W-1:0]      tat_wide;
   logic [WIDE_W-1:0]      burst_wide;
   logic [WIDE_W-1:0]      wait_diff;

   lrt_select #(
      .TIME_BITS (TIME_BITS),
      .IDX_W     (IDX_W)
   ) u_select (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (sel_ctrl),
      .entry_valid (valid_ff[cmp_idx_ff]),
      .entry_idx   (cmp_idx_ff),
      .entry_rem   (rd_data_ff[TIME_BITS-1:0]),
      .entry_arr   (rd_data_ff[2*TIME_BITS-1:TIME_BITS]),
      .entry_burst (rd_data_ff[WORD_W-1:2*TIME_BITS]),
      .cur_tick    (tick_ff),
      .best_found  (best_found),
      .best_idx    (best_idx),
      .best_rem    (best_rem),
      .best_arr    (best_arr),
      .best_burst  (best_burst)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_type == REQ_TICK) ? ST_SCAN : ST_RESULT;
            end
         end
         ST_SCAN: begin
            if (scan_cnt_ff == CNT_W'(NUM_SLOTS)) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: state_in = ST_FINAL;
         ST_FINAL:  state_in = ST_RESULT;
         ST_RESULT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Turnaround saturates at 16 bits; waiting floors at zero.
   assign tat_sat    = (tat_ff > TAT_W'(16'hFFFF)) ? 16'hFFFF : tat_ff[15:0];
   assign tat_wide   = WIDE_W'(tat_sat);
   assign burst_wide = WIDE_W'(best_burst);
   assign wait_diff  = tat_wide - burst_wide;

   // Outputs and datapath
   always_comb begin
      req_tready   = 1'b0;
      rsp_tvalid   = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = scan_cnt_ff[IDX_W-1:0];
      mem_we       = 1'b0;
      mem_waddr    = IDX_W'(req_slot);
      mem_wdata    = {clamp_time(req_burst), clamp_time(req_arrival),
                      clamp_time(req_burst)};
      sel_ctrl     = '0;
      scan_cnt_in  = scan_cnt_ff;
      tick_in      = tick_ff;
      valid_in     = valid_ff;
      tat_in       = tat_ff;
      fin_in       = fin_ff;
      rsp_idle_in  = rsp_idle_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_fin_in   = rsp_fin_ff;
      rsp_tat_in   = rsp_tat_ff;
      rsp_wait_in  = rsp_wait_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_fire) begin
               rsp_idle_in = 1'b1;
               rsp_slot_in = '0;
               rsp_fin_in  = 1'b0;
               rsp_tat_in  = '0;
               rsp_wait_in = '0;
               case (req_type)
                  REQ_LOAD: begin
                     if (slot_ok) begin
                        mem_we                    = 1'b1;
                        valid_in[IDX_W'(req_slot)] = 1'b1;
                     end
                  end
                  REQ_TICK: begin
                     sel_ctrl.clear = 1'b1;
                     scan_cnt_in    = '0;
                  end
                  REQ_RESTART: begin
                     valid_in = '0;
                     tick_in  = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            // Reads are registered, so the comparator sees each slot in the cycle after its read.
            sel_ctrl.enable = cmp_en_ff;
            if (scan_cnt_ff != CNT_W'(NUM_SLOTS)) begin
               rd_en       = 1'b1;
               scan_cnt_in = scan_cnt_ff + CNT_W'(1);
            end
         end
         ST_UPDATE: begin
            if (best_found) begin
               mem_we    = 1'b1;
               mem_waddr = best_idx;
               mem_wdata = {best_burst, best_arr, best_rem - TIME_BITS'(1)};
            end
            fin_in  = best_found && (best_rem == TIME_BITS'(1));
            tat_in  = TAT_W'(tick_ff) - TAT_W'(best_arr) + TAT_W'(1);
            tick_in = (tick_ff == TIME_MAX) ? tick_ff : tick_ff + TIME_BITS'(1);
         end
         ST_FINAL: begin
            rsp_idle_in = !best_found;
            rsp_slot_in = best_found ? 4'(best_idx) : 4'd0;
            rsp_fin_in  = fin_ff;
            rsp_tat_in  = fin_ff ? tat_sat : 16'd0;
            rsp_wait_in = (fin_ff && (tat_wide > burst_wide)) ? wait_diff[15:0] : 16'd0;
         end
         ST_RESULT: begin
            rsp_tvalid = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         tick_ff   <= '0;
         valid_ff  <= '0;
         cmp_en_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         tick_ff   <= tick_in;
         valid_ff  <= valid_in;
         cmp_en_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      scan_cnt_ff <= scan_cnt_in;
      cmp_idx_ff  <= rd_addr;
      tat_ff      <= tat_in;
      fin_ff      <= fin_in;
      rsp_idle_ff <= rsp_idle_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_fin_ff  <= rsp_fin_in;
      rsp_tat_ff  <= rsp_tat_in;
      rsp_wait_ff <= rsp_wait_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_tdata = {3'd0, rsp_wait_ff, rsp_tat_ff, rsp_fin_ff, rsp_slot_ff};
   assign rsp_tuser = rsp_idle_ff;

   // A held result blocks new requests.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request accepted while a result is pending");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_cnt_ff <= CNT_W'(NUM_SLOTS)))
      else $error("scan counter beyond the slot table");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE && tick_ff == TIME_MAX) |=> (tick_ff == TIME_MAX))
      else $error("time counter wrapped instead of saturating");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_slot_ff == 4'd0 && !rsp_fin_ff))
      else $error("idle result carries a slot or a completion");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_fin_ff) |-> (rsp_wait_ff <= rsp_tat_ff))
      else $error("waiting time exceeds turnaround");

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Longest-remaining-time scheduler testbench
// Drives load, tick, restart and unused-code transactions into the scheduler.
// Each result is checked field by field against a predictor kept alongside the
// stimulus, or a directed row's own expectation. A short directed table comes
// first, then random traffic under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb import lrt_pkg::*; ();

   localparam int SLOT_COUNT   = 16;
   localparam int RANDOM_ITEMS = 1850;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = SLOT_COUNT + 14;
   localparam int QUIET_LIMIT  = 4000;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  slot;
      logic [15:0] arrival;
      logic [15:0] burst;
   } sched_request_type;

   typedef struct packed {
      logic        is_idle;
      logic [3:0]  chosen_slot;
      logic        finished;
      logic [15:0] turnaround;
      logic [15:0] waiting;
   } sched_result_type;

   typedef struct packed {
      sched_request_type req;
      logic              fixed;
      sched_result_type  want;
   } directed_row_type;

   localparam sched_result_type IDLE_RESULT = {1'b1, 4'd0, 1'b0, 16'd0, 16'd0};
   localparam sched_result_type NO_RESULT   = '0;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;  // slot_index, arrival_time, burst_time, zero pad
   logic [1:0]  req_tuser;  // req_type
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;  // chosen_slot, finished, turnaround, waiting, zero pad
   logic [0:0]  rsp_tuser;  // is_idle

   // Sideband travelling with each request: a hand-written expectation, if any.
   logic             drv_fixed;
   sched_result_type drv_want;

   // Predictor state.
   logic [15:0] arrival_at [SLOT_COUNT];
   logic [15:0] burst_len [SLOT_COUNT];
   logic [15:0] left_to_run [SLOT_COUNT];
   logic [15:0] now_tick;

   sched_result_type pending_results[$];
   directed_row_type directed_rows[$];

   int  sent_count = 0;
   int  seen_count = 0;
   int  fault_count = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  quiet_cycles = 0;
   bit  hold_wanted = 1'b0;

   longest_remaining_time_scheduler #(
      .NUM_SLOTS(SLOT_COUNT),
      .TIME_BITS(16)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic void clear_schedule();
      for (int k = 0; k < SLOT_COUNT; k++) begin
         arrival_at[k]  = '0;
         burst_len[k]   = '0;
         left_to_run[k] = '0;
      end
      now_tick = '0;
   endfunction

   // Applies one request to the predictor state and returns the result it gives.
   function automatic sched_result_type serve_request(input sched_request_type r);
      sched_result_type res;
      int               pick;
      logic [15:0]      top_left;
      logic [16:0]      span;
      res = IDLE_RESULT;
      pick = -1;
      top_left = '0;
      case (r.kind)
         REQ_LOAD: begin
            arrival_at[r.slot]  = r.arrival;
            burst_len[r.slot]   = r.burst;
            left_to_run[r.slot] = r.burst;
         end
         REQ_RESTART: begin
            clear_schedule();
         end
         REQ_TICK: begin
            // Strict comparison keeps the lowest index on a tie.
            for (int k = 0; k < SLOT_COUNT; k++) begin
               if (arrival_at[k] <= now_tick && left_to_run[k] != 0 &&
                   (pick < 0 || left_to_run[k] > top_left)) begin
                  pick = k;
                  top_left = left_to_run[k];
               end
            end
            if (pick >= 0) begin
               left_to_run[pick] = left_to_run[pick] - 16'd1;
               res.is_idle = 1'b0;
               res.chosen_slot = pick[3:0];
               if (left_to_run[pick] == 0) begin
                  span = {1'b0, now_tick} + 17'd1 - {1'b0, arrival_at[pick]};
                  if (span > 17'h0FFFF)
                     span = 17'h0FFFF;
                  res.finished = 1'b1;
                  res.turnaround = span[15:0];
                  res.waiting = (span[15:0] > burst_len[pick]) ?
                                span[15:0] - burst_len[pick] : 16'd0;
               end
            end
            if (now_tick != 16'hFFFF)
               now_tick = now_tick + 16'd1;
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fault_count++;
      end
   endtask

   // Results are checked before the new request is predicted, so a result and a
   // request accepted at the same edge never see each other out of order.
   always @(posedge clock) begin : score_results
      sched_result_type got;
      sched_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser[0], rsp_tdata[3:0], rsp_tdata[4], rsp_tdata[20:5],
                   rsp_tdata[36:21]};
            seen_count++;
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result, actual %0h", $time, got);
               fault_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("is_idle", 16'(want.is_idle), 16'(got.is_idle));
               check_field("chosen_slot", 16'(want.chosen_slot), 16'(got.chosen_slot));
               check_field("finished", 16'(want.finished), 16'(got.finished));
               check_field("turnaround", want.turnaround, got.turnaround);
               check_field("waiting", want.waiting, got.waiting);
            end
         end
         if (req_tvalid && req_tready) begin
            want = serve_request({req_tuser, req_tdata[3:0], req_tdata[19:4],
                                  req_tdata[35:20]});
            if (drv_fixed)
               want = drv_want;
            pending_results.push_back(want);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_wanted) begin
            hold_wanted = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_item(input sched_request_type r, input logic fixed,
                            input sched_result_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= r.kind;
      req_tdata <= {4'd0, r.burst, r.arrival, r.slot};
      drv_fixed <= fixed;
      drv_want <= want;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (seen_count != sent_count) @(posedge clock);
   endtask

   task automatic add_row(input logic [1:0] kind, input logic [3:0] slot,
                          input logic [15:0] arrival, input logic [15:0] burst,
                          input logic fixed, input sched_result_type want);
      directed_rows.push_back({kind, slot, arrival, burst, fixed, want});
   endtask

   // Mostly ticks, interleaved with loads that mostly arrive soon with short bursts;
   // long bursts, far arrivals, restarts and the unused code are rarer.
   function automatic sched_request_type random_request();
      sched_request_type r;
      int roll;
      roll = $urandom_range(99);
      r.slot = 4'($urandom_range(15));
      r.arrival = 16'($urandom);
      r.burst = 16'($urandom);
      if (roll < 28) begin
         r.kind = REQ_LOAD;
         if ($urandom_range(99) < 85)
            r.arrival = now_tick + 16'($urandom_range(6));
         roll = $urandom_range(99);
         if (roll < 90)
            r.burst = 16'($urandom_range(10, 1));
         else if (roll < 95)
            r.burst = '0;
      end else if (roll < 95) begin
         r.kind = REQ_TICK;
      end else if (roll < 98) begin
         r.kind = REQ_RESTART;
      end else begin
         r.kind = REQ_UNUSED;
      end
      return r;
   endfunction

   initial begin
      directed_row_type row;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= REQ_LOAD;
      drv_fixed <= 1'b0;
      drv_want <= NO_RESULT;
      clear_schedule();

      add_row(REQ_TICK, 4'd0, 16'd0, 16'd0, 1'b1, IDLE_RESULT);
      add_row(REQ_UNUSED, 4'd15, 16'hFFFF, 16'hFFFF, 1'b1, IDLE_RESULT);
      add_row(REQ_LOAD, 4'd0, 16'd0, 16'd1, 1'b1, IDLE_RESULT);
      add_row(REQ_LOAD, 4'd15, 16'd0, 16'd1, 1'b1, IDLE_RESULT);
      // Equal remaining times: the lower slot goes first.
      add_row(REQ_TICK, 4'd0, 16'd0, 16'd0, 1'b1, {1'b0, 4'd0, 1'b1, 16'd2, 16'd1});
      add_row(REQ_TICK, 4'd0, 16'd0, 16'd0, 1'b1, {1'b0, 4'd15, 1'b1, 16'd3, 16'd2});
      add_row(REQ_LOAD, 4'd3, 16'hFFFF, 16'hFFFF, 1'b1, IDLE_RESULT);
      add_row(REQ_TICK, 4'd0, 16'd0, 16'd0, 1'b1, IDLE_RESULT);
      add_row(REQ_LOAD, 4'd5, 16'd0, 16'd0, 1'b1, IDLE_RESULT);
      add_row(REQ_TICK, 4'd0, 16'd0, 16'd0, 1'b1, IDLE_RESULT);
      add_row(REQ_LOAD, 4'd7, 16'd0, 16'd3, 1'b1, IDLE_RESULT);
      add_row(REQ_LOAD, 4'd8, 16'd0, 16'd5, 1'b1, IDLE_RESULT);
      repeat (3) add_row(REQ_TICK, 4'd0, 16'd0, 16'd0, 1'b0, NO_RESULT);
      // Reload of a slot that is partly served.
      add_row(REQ_LOAD, 4'd8, 16'd0, 16'd6, 1'b1, IDLE_RESULT);
      repeat (2) add_row(REQ_TICK, 4'd0, 16'd0, 16'd0, 1'b0, NO_RESULT);
      add_row(REQ_LOAD, 4'd10, 16'h5555, 16'hAAAA, 1'b1, IDLE_RESULT);
      add_row(REQ_LOAD, 4'd5, 16'hAAAA, 16'h5555, 1'b1, IDLE_RESULT);
      add_row(REQ_RESTART, 4'd0, 16'd0, 16'd0, 1'b1, IDLE_RESULT);
      add_row(REQ_TICK, 4'd0, 16'd0, 16'd0, 1'b1, IDLE_RESULT);
      add_row(REQ_LOAD, 4'd9, 16'd2, 16'd2, 1'b1, IDLE_RESULT);
      repeat (3) add_row(REQ_TICK, 4'd0, 16'd0, 16'd0, 1'b0, NO_RESULT);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_item(row.req, row.fixed, row.want);
      end
      wait_for_results();

      // Long hold-off on the result side while requests keep coming.
      hold_wanted = 1'b1;
      repeat (10) send_item(random_request(), 1'b0, NO_RESULT);
      wait_for_results();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = (phase == 1) ? 69 : (phase == 3) ? 31 : 0;
         recv_stall_pct = (phase == 2) ? 69 : (phase == 3) ? 31 : 0;
         repeat (RANDOM_ITEMS / 4) send_item(random_request(), 1'b0, NO_RESULT);
         wait_for_results();
      end

      recv_stall_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, pending_results.size());
         fault_count++;
      end
      if (fault_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
